### hdl/efgw_pkg.sv
// Package for the event flag group with per-task waiters.
// Holds the transfer payload types, command and status codes, and the match
// function shared by the top level and the waiter cells. No dependencies.
package efgw_pkg;

    localparam int TASK_COUNT = 16;
    localparam int ID_W       = 6;
    localparam int WORD_W     = 32;
    localparam int WAKE_W     = 16;

    localparam logic [1:0] CMD_WAIT    = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_NOWAIT  = 2'd3;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_TIMED = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [3:0]        task_id;
        logic [WORD_W-1:0] care_mask;
        logic              match_all;
        logic              release_on_match;
        logic [1:0]        wait_mode;
        logic [4:0]        bit_index;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [WAKE_W-1:0] wake_mask;
        logic [WORD_W-1:0] event_flags;
    } rsp_t;

    // Command broadcast to every cell in the execute cycle.
    typedef struct packed {
        logic              fire;
        logic [1:0]        cmd;
        logic [ID_W-1:0]   tid;
        logic [WORD_W-1:0] mask;
        logic              all;
        logic              rel;
        logic              timed;
        logic              block;
        logic [WORD_W-1:0] probe;
    } bcast_t;

    // Data handed from one cell to the next along the chain.
    typedef struct packed {
        logic [WORD_W-1:0] freed;
        logic              hit;
        logic              hit_match;
    } link_t;

    function automatic logic flags_match(input logic [WORD_W-1:0] word,
                                         input logic [WORD_W-1:0] mask,
                                         input logic all);
        logic [WORD_W-1:0] hit_bits;
        hit_bits = word & mask;
        if (all)
            return hit_bits == mask;
        return hit_bits != '0;
    endfunction

endpackage

### hdl/efgw_cell.sv
// One waiter cell: holds the wait entry of a single task.
// Tests its entry against the broadcast word and passes the accumulated
// release mask and timeout outcome to its neighbor. Depends on efgw_pkg.
module efgw_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [efgw_pkg::ID_W-1:0] idx,
    input  efgw_pkg::bcast_t       bc,
    input  efgw_pkg::link_t        link_in,
    output efgw_pkg::link_t        link_out,
    output logic                   wake
);
    import efgw_pkg::*;

    logic              blocked_reg;
    logic              blocked_next;
    logic [WORD_W-1:0] mask_reg;
    logic              all_reg;
    logic              rel_reg;
    logic              timed_reg;

    logic sel;
    logic match;
    logic set_hit;
    logic tmo_hit;
    logic write_entry;

    assign sel     = bc.tid == idx;
    assign match   = flags_match(bc.probe, mask_reg, all_reg);
    // Task zero is never woken by a set.
    assign set_hit = bc.fire && bc.cmd == CMD_SET && blocked_reg && idx != '0 && match;
    assign tmo_hit = bc.fire && bc.cmd == CMD_TIMEOUT && sel && blocked_reg && timed_reg;
    assign write_entry = bc.fire && bc.block && sel;

    assign wake = set_hit;

    always_comb
    begin
        link_out = link_in;
        if ((set_hit || tmo_hit) && rel_reg)
            link_out.freed = link_in.freed | mask_reg;
        if (tmo_hit)
        begin
            link_out.hit       = 1'b1;
            link_out.hit_match = match;
        end
    end

    always_comb
    begin
        blocked_next = blocked_reg;
        if (write_entry)
            blocked_next = 1'b1;
        else if (set_hit || tmo_hit)
            blocked_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blocked_reg <= 1'b0;
        else
            blocked_reg <= blocked_next;
    end

    always_ff @(posedge clk)
    begin
        if (write_entry)
        begin
            mask_reg  <= bc.mask;
            all_reg   <= bc.all;
            rel_reg   <= bc.rel;
            timed_reg <= bc.timed;
        end
    end

endmodule

### hdl/event_flag_group_waiters.sv
// Event flag group: a 32-bit event word and a chain of per-task waiter cells.
// A request transfer is captured, then executed into the response register on rsp.
// No request is taken while one is held; the execute cycle walks the cell chain.
// A stalled response holds the execute cycle until the output register frees.
// Reset (rst_n low, asynchronous) clears the event word and every blocked flag.
module event_flag_group_waiters (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  efgw_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output efgw_pkg::rsp_t  rsp
);
    import efgw_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    req_t              item_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              accept;
    logic              exec;
    logic              in_range;
    logic              wait_match;
    logic [WORD_W-1:0] word_set;
    logic [TASK_COUNT-1:0] wake_vec;
    logic [WAKE_W-1:0] wake_out;
    bcast_t            bc;
    link_t             chain [TASK_COUNT+1];

    assign req_stall = busy_reg;
    assign accept    = req_valid && !busy_reg;
    assign exec      = busy_reg && (!rsp_valid_reg || !rsp_stall);

    assign in_range   = {2'b00, item_reg.task_id} < ID_W'(TASK_COUNT);
    assign wait_match = flags_match(word_reg, item_reg.care_mask, item_reg.match_all);
    assign word_set   = word_reg | (WORD_W'(1) << item_reg.bit_index);

    always_comb
    begin
        bc.fire  = exec;
        bc.cmd   = item_reg.cmd;
        bc.tid   = {2'b00, item_reg.task_id};
        bc.mask  = item_reg.care_mask;
        bc.all   = item_reg.match_all;
        bc.rel   = item_reg.release_on_match;
        bc.timed = item_reg.wait_mode == MODE_TIMED;
        bc.block = item_reg.cmd == CMD_WAIT && in_range && !wait_match
                   && item_reg.wait_mode != MODE_NONE;
        bc.probe = (item_reg.cmd == CMD_SET) ? word_set : word_reg;
    end

    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TASK_COUNT; gi++)
        begin : g_cell
            efgw_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (ID_W'(gi)),
                .bc       (bc),
                .link_in  (chain[gi]),
                .link_out (chain[gi+1]),
                .wake     (wake_vec[gi])
            );
        end
        // Only the first sixteen tasks can be reported in the wake mask.
        if (TASK_COUNT >= WAKE_W)
        begin : g_wake_trunc
            assign wake_out = wake_vec[WAKE_W-1:0];
        end
        else
        begin : g_wake_ext
            assign wake_out = WAKE_W'(wake_vec);
        end
    endgenerate

    always_comb
    begin
        word_next = word_reg;
        rsp_next  = rsp_reg;
        rsp_next.status    = ST_NOWAIT;
        rsp_next.wake_mask = '0;
        case (item_reg.cmd)
            CMD_WAIT:
            begin
                if (!in_range)
                    rsp_next.status = ST_FAIL;
                else if (wait_match)
                begin
                    rsp_next.status = ST_OK;
                    if (item_reg.release_on_match)
                        word_next = word_reg & ~item_reg.care_mask;
                end
                else if (item_reg.wait_mode == MODE_NONE)
                    rsp_next.status = ST_FAIL;
                else
                    rsp_next.status = ST_BLOCKED;
            end
            CMD_SET:
            begin
                word_next          = word_set & ~chain[TASK_COUNT].freed;
                rsp_next.wake_mask = wake_out;
            end
            CMD_CLEAR:
            begin
                word_next = word_reg & ~(WORD_W'(1) << item_reg.bit_index);
            end
            CMD_TIMEOUT:
            begin
                if (chain[TASK_COUNT].hit)
                begin
                    rsp_next.status = chain[TASK_COUNT].hit_match ? ST_OK : ST_FAIL;
                    word_next       = word_reg & ~chain[TASK_COUNT].freed;
                end
            end
            default:
            begin
                rsp_next.status = ST_NOWAIT;
            end
        endcase
        rsp_next.event_flags = word_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (exec)
            busy_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (exec)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            word_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec)
                word_reg <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
        if (exec)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hdl/efgw_checker.sv
// Port-level checks for the event flag group, attached by bind to the top level.
// Depends on efgw_pkg and on the port list of event_flag_group_waiters.
module efgw_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input efgw_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input efgw_pkg::rsp_t rsp
);
    import efgw_pkg::*;

    // A stalled request stays valid and unchanged.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_stall) |=> (req_valid && $stable(req)))
        else $error("stalled request changed");

    // After a request transfer the block holds the item and takes no other.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while an item is in work");

    // A stalled response stays valid and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

    // Task zero is never woken by a set.
    a_no_wake_task0: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !rsp.wake_mask[0])
        else $error("task zero reported as woken");

    // Only a set reports woken tasks, and it carries no wait status.
    a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.wake_mask != '0) |-> rsp.status == ST_NOWAIT)
        else $error("woken tasks reported with a wait status");

endmodule

bind event_flag_group_waiters efgw_checker u_efgw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### tb/efgw_checker.sv
// Checker for event_flag_group_waiters: keeps its own copy of the event word and the
// waiter table, predicts one response per request transfer and compares them in order.
// Depends on efgw_pkg for the payload types and the command, status and mode codes.
module efgw_scoreboard (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  efgw_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  efgw_pkg::rsp_t rsp,
    output int             fail_count,
    output int             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import efgw_pkg::*;

    logic [WORD_W-1:0]     flags_word;
    logic [TASK_COUNT-1:0] parked;
    logic [WORD_W-1:0]     park_mask [TASK_COUNT];
    logic [TASK_COUNT-1:0] park_all;
    logic [TASK_COUNT-1:0] park_release;
    logic [TASK_COUNT-1:0] park_timed;
    rsp_t                  due_rsp [$];
    int                    errors = 0;

    function automatic logic bits_satisfied(input logic [WORD_W-1:0] word,
                                            input logic [WORD_W-1:0] mask,
                                            input logic need_all);
        if (need_all)
            return (word & mask) == mask;
        return (word & mask) != '0;
    endfunction

    // Applies one kernel call to the mirrored state and returns the response it earns.
    task automatic apply_call(input req_t r, output rsp_t o);
        logic [WORD_W-1:0] freed;
        logic [WAKE_W-1:0] woke;
        logic [1:0]        st;
        int                i;
        freed = '0;
        woke  = '0;
        st    = ST_NOWAIT;
        case (r.cmd)
            CMD_WAIT:
            begin
                if (bits_satisfied(flags_word, r.care_mask, r.match_all))
                begin
                    st = ST_OK;
                    if (r.release_on_match)
                        flags_word &= ~r.care_mask;
                end
                else if (r.wait_mode == MODE_NONE)
                begin
                    st = ST_FAIL;
                end
                else
                begin
                    // A second wait from a parked task simply replaces its entry.
                    parked[r.task_id]       = 1'b1;
                    park_mask[r.task_id]    = r.care_mask;
                    park_all[r.task_id]     = r.match_all;
                    park_release[r.task_id] = r.release_on_match;
                    park_timed[r.task_id]   = (r.wait_mode == MODE_TIMED);
                    st = ST_BLOCKED;
                end
            end
            CMD_SET:
            begin
                flags_word[r.bit_index] = 1'b1;
                // Every waiter but task zero is tested against the same word; releases are applied after.
                for (i = TASK_COUNT - 1; i > 0; i--)
                begin
                    if (parked[i] && bits_satisfied(flags_word, park_mask[i], park_all[i]))
                    begin
                        parked[i] = 1'b0;
                        woke[i]   = 1'b1;
                        if (park_release[i])
                            freed |= park_mask[i];
                    end
                end
                flags_word &= ~freed;
            end
            CMD_CLEAR:
            begin
                flags_word[r.bit_index] = 1'b0;
            end
            default:
            begin
                if (parked[r.task_id] && park_timed[r.task_id])
                begin
                    parked[r.task_id] = 1'b0;
                    st = bits_satisfied(flags_word, park_mask[r.task_id], park_all[r.task_id])
                         ? ST_OK : ST_FAIL;
                    // The release happens even when the recheck fails.
                    if (park_release[r.task_id])
                        flags_word &= ~park_mask[r.task_id];
                end
            end
        endcase
        o.status      = st;
        o.wake_mask   = woke;
        o.event_flags = flags_word;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t fresh;
        if (!rst_n)
        begin
            flags_word   = '0;
            parked       = '0;
            park_all     = '0;
            park_release = '0;
            park_timed   = '0;
            for (int k = 0; k < TASK_COUNT; k++)
                park_mask[k] = '0;
            due_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.wake_mask !== want.wake_mask)
                    begin
                        $error("wake_mask: expected %h, got %h", want.wake_mask, rsp.wake_mask);
                        errors++;
                    end
                    if (rsp.event_flags !== want.event_flags)
                    begin
                        $error("event_flags: expected %h, got %h",
                               want.event_flags, rsp.event_flags);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                apply_call(req, fresh);
                due_rsp.push_back(fresh);
            end
            outstanding <= due_rsp.size();
        end
        fail_count <= errors;
    end

endmodule

### tb/tb_top.sv
// Top of the event_flag_group_waiters testbench: clock, reset, request stimulus and
// response back-pressure, with efgw_scoreboard doing prediction and comparison.
// Depends on efgw_pkg, the event_flag_group_waiters RTL and tb/efgw_checker.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import efgw_pkg::*;

    localparam int CALL_TARGET = 750;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [1:0] MODE_FOREVER = 2'd1;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   fail_count;
    int   outstanding;
    int   cycles;
    int   calls_sent;
    logic steady;

    event_flag_group_waiters dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    efgw_scoreboard u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short idle gaps, now and then a long one; none during steady stretches.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t make_call(input logic [1:0]  cmd,
                                       input logic [3:0]  tid,
                                       input logic [31:0] mask,
                                       input logic        need_all,
                                       input logic        rel,
                                       input logic [1:0]  mode,
                                       input logic [4:0]  bit_idx);
        req_t c;
        c.cmd              = cmd;
        c.task_id          = tid;
        c.care_mask        = mask;
        c.match_all        = need_all;
        c.release_on_match = rel;
        c.wait_mode        = mode;
        c.bit_index        = bit_idx;
        return c;
    endfunction

    // Bits are drawn from an eight-bit window so that sets and waits meet often.
    function automatic logic [4:0] pool_bit(input logic [4:0] base);
        return base + 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] pool_mask(input logic [4:0] base);
        logic [31:0] m;
        int          r;
        int          n;
        r = $urandom_range(0, 39);
        if (r == 0)
            return '0;
        if (r < 5)
            return $urandom;
        m = '0;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
            m[pool_bit(base)] = 1'b1;
        return m;
    endfunction

    task automatic issue(input req_t item);
        int gap;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        calls_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A few tasks park on one bit window, then the window is poked with sets,
    // clears and timeouts.
    task automatic waiter_scene();
        logic [4:0] base;
        logic [3:0] tid;
        logic [1:0] mode;
        int         crowd;
        int         pokes;
        int         r;
        base = 5'($urandom);
        tid  = 4'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            issue(make_call(CMD_CLEAR, 4'($urandom), '0, 1'b0, 1'b0, MODE_NONE, pool_bit(base)));
            issue(make_call(CMD_CLEAR, 4'($urandom), '0, 1'b0, 1'b0, MODE_NONE, pool_bit(base)));
        end
        crowd = $urandom_range(1, 4);
        for (int k = 0; k < crowd; k++)
        begin
            tid  = 4'($urandom);
            mode = ($urandom_range(0, 7) == 0) ? MODE_NONE : 2'($urandom_range(1, 3));
            issue(make_call(CMD_WAIT, tid, pool_mask(base), 1'($urandom), 1'($urandom),
                            mode, 5'($urandom)));
        end
        pokes = $urandom_range(0, 4);
        for (int k = 0; k < pokes; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                issue(make_call(CMD_SET, 4'($urandom), $urandom, 1'($urandom),
                                1'($urandom), 2'($urandom), pool_bit(base)));
            else if (r < 9)
                issue(make_call(CMD_CLEAR, 4'($urandom), $urandom, 1'($urandom),
                                1'($urandom), 2'($urandom), pool_bit(base)));
            else
                issue(make_call(CMD_TIMEOUT, 4'($urandom), $urandom, 1'($urandom),
                                1'($urandom), 2'($urandom), 5'($urandom)));
        end
        if ($urandom_range(0, 2) == 0)
            issue(make_call(CMD_TIMEOUT, tid, $urandom, 1'($urandom), 1'($urandom),
                            2'($urandom), 5'($urandom)));
    endtask

    initial
    begin
        int run;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            run = pick_gap();
            if (run > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    initial
    begin
        int random_start;
        req_valid  = 1'b0;
        req        = '0;
        steady     = 1'b0;
        calls_sent = 0;
        rst_n      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, the empty mask, and immediate success and failure.
        issue(make_call(CMD_WAIT, 4'd1, 32'hFFFF_FFFF, 1'b1, 1'b0, MODE_NONE, 5'd0));
        issue(make_call(CMD_WAIT, 4'd0, 32'h0, 1'b1, 1'b1, MODE_NONE, 5'd0));
        issue(make_call(CMD_WAIT, 4'd15, 32'h0, 1'b0, 1'b0, MODE_NONE, 5'd31));
        issue(make_call(CMD_SET, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd31));
        issue(make_call(CMD_SET, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd0));
        issue(make_call(CMD_WAIT, 4'd15, 32'h8000_0001, 1'b1, 1'b1, MODE_NONE, 5'd0));
        // Task zero parks beside two others; sets wake only the others.
        issue(make_call(CMD_WAIT, 4'd0, 32'h0000_0020, 1'b0, 1'b1, MODE_TIMED, 5'd0));
        issue(make_call(CMD_WAIT, 4'd3, 32'h0000_0020, 1'b0, 1'b0, MODE_FOREVER, 5'd0));
        issue(make_call(CMD_WAIT, 4'd4, 32'h0000_0060, 1'b1, 1'b1, MODE_SPARE, 5'd0));
        issue(make_call(CMD_SET, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd5));
        issue(make_call(CMD_SET, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd6));
        issue(make_call(CMD_TIMEOUT, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd0));
        // A failed timed wait still gives back its bits.
        issue(make_call(CMD_WAIT, 4'd0, 32'h0000_0180, 1'b1, 1'b1, MODE_TIMED, 5'd0));
        issue(make_call(CMD_SET, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd7));
        issue(make_call(CMD_TIMEOUT, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd0));
        // Timeouts with nothing to end, and a wait that replaces an earlier one.
        issue(make_call(CMD_TIMEOUT, 4'd2, '0, 1'b0, 1'b0, MODE_NONE, 5'd0));
        issue(make_call(CMD_WAIT, 4'd5, 32'h0000_0200, 1'b0, 1'b0, MODE_FOREVER, 5'd0));
        issue(make_call(CMD_TIMEOUT, 4'd5, '0, 1'b0, 1'b0, MODE_NONE, 5'd0));
        issue(make_call(CMD_WAIT, 4'd5, 32'h0000_0400, 1'b0, 1'b0, MODE_TIMED, 5'd0));
        issue(make_call(CMD_SET, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd9));
        issue(make_call(CMD_TIMEOUT, 4'd5, '0, 1'b0, 1'b0, MODE_NONE, 5'd0));
        // An immediate failure keeps the word untouched.
        issue(make_call(CMD_SET, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd12));
        issue(make_call(CMD_WAIT, 4'd6, 32'h0000_3000, 1'b1, 1'b1, MODE_NONE, 5'd0));
        issue(make_call(CMD_CLEAR, 4'd15, '1, 1'b1, 1'b1, MODE_SPARE, 5'd9));
        issue(make_call(CMD_CLEAR, 4'd0, '0, 1'b0, 1'b0, MODE_NONE, 5'd31));

        random_start = calls_sent;
        while (calls_sent - random_start < CALL_TARGET)
        begin
            steady = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 7)
                waiter_scene();
            else
                issue(make_call(2'($urandom), 4'($urandom), $urandom, 1'($urandom),
                                1'($urandom), 2'($urandom), 5'($urandom)));
        end
        req_valid <= 1'b0;
        steady = 1'b0;

        // The outstanding count is registered, so it trails the last request transfer.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/efgw_pkg.sv
hdl/efgw_cell.sv
hdl/event_flag_group_waiters.sv
hdl/efgw_checker.sv
tb/efgw_checker.sv
tb/tb_top.sv
